### rtl/core/ild_pkg.sv
// Shared types, opcode constants and opcode table functions of the instruction length decoder.
`default_nettype none

package ild_pkg;

	// Decode phase of the current instruction, one-hot
	typedef enum logic [5:0] {
		PH_PREFIX = 6'b000001,
		PH_ESC2   = 6'b000010,
		PH_ESC3   = 6'b000100,
		PH_MODRM  = 6'b001000,
		PH_SIB    = 6'b010000,
		PH_TAIL   = 6'b100000
	} phase_t;

	// Opcode escape seen before the opcode byte
	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_0F   = 2'd1,
		ESC_0F38 = 2'd2,
		ESC_0F3A = 2'd3
	} esc_t;

	// Per-instruction decode state
	typedef struct packed {
		phase_t     phase;
		logic [3:0] seen;
		logic       addr_ovr;
		logic       rex_w;
		logic [7:0] opcode;
		esc_t       esc;
		logic [1:0] modf;
		logic [3:0] tail;
	} ild_state_t;

	localparam ild_state_t STATE_CLEAR = '{
		phase:    PH_PREFIX,
		seen:     4'd0,
		addr_ovr: 1'b0,
		rex_w:    1'b0,
		opcode:   8'h00,
		esc:      ESC_NONE,
		modf:     2'd0,
		tail:     4'd0
	};

	// Input beat held in the input register
	typedef struct packed {
		logic       valid;
		logic [7:0] code;
		logic       restart;
	} beat_t;

	// Result of one decode step
	typedef struct packed {
		logic       emit;
		logic [3:0] len;
		logic       too_long;
	} result_t;

	localparam logic [7:0] OP_ESC      = 8'h0F;
	localparam logic [7:0] OP_ESC_38   = 8'h38;
	localparam logic [7:0] OP_ESC_3A   = 8'h3A;
	localparam logic [7:0] PFX_ADDR    = 8'h67;
	localparam logic [7:0] REX_LO      = 8'h40;
	localparam logic [7:0] REX_HI      = 8'h4F;

	localparam logic [1:0] MOD_NONE    = 2'd0;
	localparam logic [1:0] MOD_DISP8   = 2'd1;
	localparam logic [1:0] MOD_DISP32  = 2'd2;
	localparam logic [1:0] MOD_REG     = 2'd3;
	localparam logic [2:0] RM_SIB      = 3'd4;
	localparam logic [2:0] RM_DISP     = 3'd5;

	function automatic logic is_legacy_prefix(input logic [7:0] b);
		return b == 8'hF0 || b == 8'hF2 || b == 8'hF3 || b == 8'h2E || b == 8'h36 ||
		       b == 8'h3E || b == 8'h26 || b == 8'h64 || b == 8'h65 || b == 8'h66;
	endfunction

	function automatic logic is_rex(input logic [7:0] b);
		return b >= REX_LO && b <= REX_HI;
	endfunction

	// One-byte opcodes followed by ModRM
	function automatic logic takes_modrm(input logic [7:0] op);
		return (op < 8'h40 && op[2:0] < 3'd4) ||
		       op == 8'h62 || op == 8'h63 || op == 8'h69 || op == 8'h6B ||
		       op[7:4] == 4'h8 ||
		       op == 8'hC0 || op == 8'hC1 || (op >= 8'hC4 && op <= 8'hC7) ||
		       (op >= 8'hD0 && op <= 8'hD3) || (op >= 8'hD8 && op <= 8'hDF) ||
		       op == 8'hF6 || op == 8'hF7 || op == 8'hFE || op == 8'hFF;
	endfunction

	// Two-byte opcodes with nothing after them
	function automatic logic two_byte_bare(input logic [7:0] op);
		return op == 8'h05 || op == 8'h07 || op == 8'h0B ||
		       (op >= 8'h30 && op <= 8'h35) || op == 8'h37 || op == 8'h77 ||
		       op == 8'hA0 || op == 8'hA1 || op == 8'hA2 || op == 8'hA8 ||
		       op == 8'hA9 || op == 8'hAA;
	endfunction

	// Immediate bytes after the ModRM, SIB and displacement group
	function automatic logic [3:0] imm_after_modrm(input logic [7:0] op, input esc_t esc);
		logic [3:0] r;
		r = 4'd0;
		if (esc == ESC_0F3A) begin
			r = 4'd1;
		end else if (esc == ESC_NONE) begin
			case (op) inside
				8'h80, 8'h82, 8'h83, 8'h6B, 8'hC6, 8'hF6: r = 4'd1;
				8'h81, 8'h69, 8'hC7, 8'hF7:               r = 4'd4;
				default:                                  r = 4'd0;
			endcase
		end
		return r;
	endfunction

	// Immediate bytes of a one-byte opcode without ModRM
	function automatic logic [3:0] plain_imm(input logic [7:0] op, input logic rex_w,
	                                         input logic addr_ovr);
		logic [3:0] r;
		case (op) inside
			[8'h70:8'h7F]:                r = 4'd1;
			8'hE8, 8'hE9, 8'h68:          r = 4'd4;
			8'hEB, 8'h6A, 8'hCD:          r = 4'd1;
			[8'hB0:8'hB7]:                r = 4'd1;
			[8'hB8:8'hBF]:                r = rex_w ? 4'd8 : 4'd4;
			8'hC2, 8'hCA:                 r = 4'd2;
			8'hC8:                        r = 4'd3;
			[8'hA0:8'hA3]:                r = addr_ovr ? 4'd4 : 4'd8;
			default:                      r = 4'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/ild_in_stage.sv
// Input register of the instruction length decoder.
`default_nettype none

module ild_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           byte_valid,
	input  logic [7:0]     code_byte,
	input  logic           restart,
	input  logic           advance,
	output logic           byte_stall,
	output ild_pkg::beat_t beat_s1
);
	import ild_pkg::*;

	logic       valid_s1;
	logic [7:0] code_s1;
	logic       restart_s1;

	// Hold off the sender while a beat waits on a blocked result register
	assign byte_stall = valid_s1 && !advance;

	// Track occupancy of the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	// Capture the payload of an accepted beat
	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			code_s1    <= code_byte;
			restart_s1 <= restart;
		end
	end

	assign beat_s1 = '{valid: valid_s1, code: code_s1, restart: restart_s1};

endmodule

`default_nettype wire

### rtl/core/ild_core.sv
// Per-byte decode logic and instruction state of the instruction length decoder.
`default_nettype none

module ild_core #(
	parameter int MAX_INSN_LEN = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  ild_pkg::beat_t   beat_s1,
	output ild_pkg::result_t res
);
	import ild_pkg::*;

	localparam logic [3:0] MaxLen = 4'(MAX_INSN_LEN);

	ild_state_t st_q;
	ild_state_t cur;
	ild_state_t nxt;
	ild_state_t nxt_fin;
	logic [7:0] b;
	logic [3:0] seen;
	logic [3:0] disp;
	logic [3:0] n;
	logic       to_tail;
	logic       done;
	logic       cut;

	assign b = beat_s1.code;

	// Decode one code byte against the held state
	always_comb begin
		cur = st_q;
		if (beat_s1.restart) begin
			cur = STATE_CLEAR;
		end
		seen    = cur.seen + 4'd1;
		nxt     = cur;
		done    = 1'b0;
		to_tail = 1'b0;
		disp    = 4'd0;
		n       = 4'd0;
		unique case (cur.phase)
			PH_ESC2: begin
				nxt.opcode = b;
				if (b[7:4] == 4'h8) begin
					to_tail = 1'b1;
					n       = 4'd4;
				end else if (two_byte_bare(b)) begin
					done = 1'b1;
				end else if (b == OP_ESC_38 || b == OP_ESC_3A) begin
					nxt.esc   = (b == OP_ESC_38) ? ESC_0F38 : ESC_0F3A;
					nxt.phase = PH_ESC3;
				end else begin
					nxt.esc   = ESC_0F;
					nxt.phase = PH_MODRM;
				end
			end
			PH_ESC3: begin
				nxt.opcode = b;
				nxt.phase  = PH_MODRM;
			end
			PH_MODRM: begin
				nxt.modf = b[7:6];
				if (b[7:6] != MOD_REG && b[2:0] == RM_SIB) begin
					nxt.phase = PH_SIB;
				end else begin
					if (b[7:6] == MOD_NONE && b[2:0] == RM_DISP) begin
						disp = 4'd4;
					end else if (b[7:6] == MOD_DISP8) begin
						disp = 4'd1;
					end else if (b[7:6] == MOD_DISP32) begin
						disp = 4'd4;
					end
					to_tail = 1'b1;
					n       = disp + imm_after_modrm(cur.opcode, cur.esc);
				end
			end
			PH_SIB: begin
				if (cur.modf == MOD_NONE && b[2:0] == RM_DISP) begin
					disp = 4'd4;
				end else if (cur.modf == MOD_DISP8) begin
					disp = 4'd1;
				end else if (cur.modf == MOD_DISP32) begin
					disp = 4'd4;
				end
				to_tail = 1'b1;
				n       = disp + imm_after_modrm(cur.opcode, cur.esc);
			end
			PH_TAIL: begin
				nxt.tail = cur.tail - 4'd1;
				done     = (nxt.tail == 4'd0);
			end
			PH_PREFIX: begin
				if (is_legacy_prefix(b)) begin
					nxt = cur;
				end else if (b == PFX_ADDR) begin
					nxt.addr_ovr = 1'b1;
				end else if (is_rex(b)) begin
					nxt.rex_w = b[3];
				end else begin
					nxt.opcode = b;
					nxt.esc    = ESC_NONE;
					if (b == OP_ESC) begin
						nxt.phase = PH_ESC2;
					end else if (takes_modrm(b)) begin
						nxt.phase = PH_MODRM;
					end else begin
						to_tail = 1'b1;
						n       = plain_imm(b, cur.rex_w, cur.addr_ovr);
					end
				end
			end
			default: begin
				nxt = cur;
			end
		endcase

		// Enter the tail, or end here when nothing follows
		if (to_tail) begin
			if (n == 4'd0) begin
				done = 1'b1;
			end else begin
				nxt.tail  = n;
				nxt.phase = PH_TAIL;
			end
		end

		cut = !done && (seen >= MaxLen);
		if (done || cut) begin
			nxt_fin = STATE_CLEAR;
		end else begin
			nxt_fin      = nxt;
			nxt_fin.seen = seen;
		end
	end

	assign res = '{emit: step && (done || cut), len: seen, too_long: cut};

	// Advance the instruction state once per decoded beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_CLEAR;
		end else if (step) begin
			st_q <= nxt_fin;
		end
	end

	// An instruction in progress never holds the cut-off length
	a_seen_below_max: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.seen < MaxLen)
		else $error("byte count reached the maximum without a result");

	// A result leaves the decoder ready for a fresh instruction
	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		res.emit |=> (st_q.seen == 4'd0 && st_q.phase == PH_PREFIX))
		else $error("state not cleared after a result");

	// The tail phase always has bytes left to take
	a_tail_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_TAIL |-> st_q.tail != 4'd0)
		else $error("tail phase with no bytes left");

endmodule

`default_nettype wire

### rtl/core/x86_64_instruction_length_decoder_top.sv
// Top level of the x86-64 instruction length decoder: input register, decode core, result register.
//
//  channel | handshake               | payload
//  --------+-------------------------+----------------------------
//  byte    | byte_valid / byte_stall | code_byte[7:0], restart
//  len     | len_valid  / len_stall  | insn_length[3:0], too_long
//
// One code byte is taken per clock while byte_stall is low; the decode state updates once per byte.
// A result on len is registered in the result register after its last byte has left the input register.
// The state loop through the decode core sets the rate of one byte per cycle while byte is not stalled.
// Reset (arst_n low) clears the decode state and both valid flags.
// While len is stalled with a result held, byte stalls once the input register is full.
`default_nettype none

module x86_64_instruction_length_decoder_top #(
	parameter int MAX_INSN_LEN = 15
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] code_byte,
	input  logic       restart,
	output logic       len_valid,
	input  logic       len_stall,
	output logic [3:0] insn_length,
	output logic       too_long
);
	import ild_pkg::*;

	beat_t      beat_s1;
	result_t    res;
	logic       advance;
	logic       step;
	logic       len_valid_q;
	logic [3:0] insn_length_q;
	logic       too_long_q;

	// Move the input register on when the result register can take a beat
	assign advance = !len_valid_q || !len_stall;
	assign step    = beat_s1.valid && advance;

	ild_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.code_byte  (code_byte),
		.restart    (restart),
		.advance    (advance),
		.byte_stall (byte_stall),
		.beat_s1    (beat_s1)
	);

	ild_core #(
		.MAX_INSN_LEN (MAX_INSN_LEN)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.beat_s1 (beat_s1),
		.res     (res)
	);

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_valid_q <= 1'b0;
		end else if (advance) begin
			len_valid_q <= res.emit;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			insn_length_q <= res.len;
			too_long_q    <= res.too_long;
		end
	end

	assign len_valid   = len_valid_q;
	assign insn_length = insn_length_q;
	assign too_long    = too_long_q;

	// A cut-off instruction always reports the maximum length
	a_cut_len: assert property (@(posedge clk) disable iff (!arst_n)
		(len_valid_q && too_long_q) |-> insn_length_q == 4'(MAX_INSN_LEN))
		else $error("cut-off result with wrong length");

	// A held result blocks the input register from moving
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(len_valid_q && len_stall && beat_s1.valid) |-> byte_stall)
		else $error("input accepted while a full input register is blocked");

	// A result beat never reports zero bytes
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		len_valid_q |-> insn_length_q != 4'd0)
		else $error("zero-length result");

endmodule

`default_nettype wire
